>>> rtl/bole_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and codes for the bounded ordered list engine
// no dependencies; imported by bounded_ordered_list_engine

package bole_pkg;

    // list depth and derived widths
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned ADDR_W   = $clog2(CAPACITY);
    localparam int unsigned OCC_W    = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    localparam int unsigned CMP_W    = (OCC_W > POS_W) ? OCC_W : POS_W;

    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 40;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [OCC_W-1:0]    occ_t;
    typedef logic [CMP_W-1:0]    cmp_t;
    typedef logic [VALUE_W-1:0]  value_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_START    = 3'd0,
        ACT_REMOVE_START = 3'd1,
        ACT_ADD_END      = 3'd2,
        ACT_REMOVE_END   = 3'd3,
        ACT_INSERT_AT    = 3'd4,
        ACT_REMOVE_AT    = 3'd5,
        ACT_READ_AT      = 3'd6
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHECK,
        S_INS_MOVE,
        S_REM_RD,
        S_REM_GRAB,
        S_REM_CHECK,
        S_REM_MOVE,
        S_DONE
    } state_t;

endpackage

>>> rtl/bole_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies

module bole_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
// top level of the bounded ordered list engine: request decode, move sequencer, result register
// depends on bole_pkg and bole_ram

// Ordered list of up to CAPACITY signed 32-bit values, head at index 0, held in
// one ram with a single write and a single registered read port. A request comes
// in as one transfer on s_ and gives exactly one result transfer on m_ holding
// the removed or read value, a status and the new count. The entries live in
// the ram, so every insert or remove moves the later entries one place through
// that ram, one entry at a time (read, then write back). An insert walks down
// from the end to the index, a remove keeps the value there and moves later
// entries up, a read stops there, and a failed request or unused action code
// goes straight to the result. s_tready is high only while the sequencer is
// idle; the result register lets the next request in while a result still waits on m_.
// No clearing pass is needed after reset: only entries below the count are read.

module bounded_ordered_list_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: action [2:0], value [34:3], position [39:35]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bole_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: result_value [31:0], status [33:32], count [38:34], zero pad [39]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bole_pkg::M_DATA_W-1:0] m_tdata
);

    import bole_pkg::*;

    localparam occ_t OCC_FULL = occ_t'(CAPACITY);
    localparam int unsigned PAD_W = M_DATA_W - VALUE_W - STATUS_W - COUNT_W;

    // sequencer and datapath registers
    state_t  state_reg, state_next;
    occ_t    occ_reg, occ_next;
    action_t act_reg, act_next;
    value_t  val_reg, val_next;
    addr_t   idx_reg, idx_next;
    addr_t   at_reg, at_next;
    value_t  res_reg, res_next;
    status_t status_reg, status_next;

    // result register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ram controls
    logic   ram_we;
    addr_t  ram_waddr;
    value_t ram_wdata;
    addr_t  ram_raddr;
    value_t ram_rdata;

    // request fields
    action_t    in_action;
    value_t     in_value;
    logic [POS_W-1:0] in_pos;

    // decode of the incoming request
    status_t dec_status;
    logic    dec_ins;
    logic    dec_rem;
    cmp_t    dec_at;
    cmp_t    occ_ext;
    cmp_t    pos_ext;

    logic in_fire;
    logic out_free;

    assign in_action = action_t'(s_tdata[ACTION_W-1:0]);
    assign in_value  = s_tdata[ACTION_W +: VALUE_W];
    assign in_pos    = s_tdata[ACTION_W + VALUE_W +: POS_W];

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign occ_ext = cmp_t'(occ_reg);
    assign pos_ext = cmp_t'(in_pos);

    // request decode: full and empty checks come before the position check
    always_comb begin
        dec_status = STATUS_OK;
        dec_ins    = 1'b0;
        dec_rem    = 1'b0;
        dec_at     = '0;
        unique case (in_action)
            ACT_ADD_START, ACT_ADD_END, ACT_INSERT_AT: begin
                if (in_action == ACT_ADD_START) begin
                    dec_at = '0;
                end else if (in_action == ACT_ADD_END) begin
                    dec_at = occ_ext;
                end else begin
                    dec_at = pos_ext;
                end
                if (occ_reg == OCC_FULL) begin
                    dec_status = STATUS_FULL;
                end else if (dec_at > occ_ext) begin
                    dec_status = STATUS_RANGE;
                end else begin
                    dec_ins = 1'b1;
                end
            end
            ACT_REMOVE_START, ACT_REMOVE_END, ACT_REMOVE_AT, ACT_READ_AT: begin
                if (in_action == ACT_REMOVE_START) begin
                    dec_at = '0;
                end else if (in_action == ACT_REMOVE_END) begin
                    dec_at = occ_ext - cmp_t'(1);
                end else begin
                    dec_at = pos_ext;
                end
                if (occ_reg == '0) begin
                    dec_status = STATUS_EMPTY;
                end else if (dec_at >= occ_ext) begin
                    dec_status = STATUS_RANGE;
                end else begin
                    dec_rem = 1'b1;
                end
            end
            default: begin
                // unused code: no change, ok status
                dec_status = STATUS_OK;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (dec_ins) begin
                        state_next = S_INS_CHECK;
                    end else if (dec_rem) begin
                        state_next = S_REM_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_INS_CHECK: begin
                if (idx_reg == at_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_INS_MOVE;
                end
            end
            S_INS_MOVE: state_next = S_INS_CHECK;
            S_REM_RD:   state_next = S_REM_GRAB;
            S_REM_GRAB: begin
                if (act_reg == ACT_READ_AT) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_REM_CHECK;
                end
            end
            S_REM_CHECK: begin
                if (occ_t'(idx_reg) + occ_t'(1) == occ_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_REM_MOVE;
                end
            end
            S_REM_MOVE: state_next = S_REM_CHECK;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, ram controls and result register
    always_comb begin
        occ_next      = occ_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        at_next       = at_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = idx_reg;

        // result leaves on a completed m_ transfer
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    act_next    = in_action;
                    val_next    = in_value;
                    at_next     = addr_t'(dec_at);
                    res_next    = '0;
                    status_next = dec_status;
                    // insert walks down from the current end, remove up from the index
                    if (dec_ins) begin
                        idx_next = addr_t'(occ_reg);
                    end else begin
                        idx_next = addr_t'(dec_at);
                    end
                end
            end
            S_INS_CHECK: begin
                if (idx_reg == at_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = at_reg;
                    ram_wdata = val_reg;
                    occ_next  = occ_reg + occ_t'(1);
                end else begin
                    ram_raddr = idx_reg - addr_t'(1);
                end
            end
            S_INS_MOVE: begin
                // entry from idx-1 lands at idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg - addr_t'(1);
            end
            S_REM_RD: begin
                ram_raddr = idx_reg;
            end
            S_REM_GRAB: begin
                res_next = ram_rdata;
            end
            S_REM_CHECK: begin
                if (occ_t'(idx_reg) + occ_t'(1) == occ_reg) begin
                    occ_next = occ_reg - occ_t'(1);
                end else begin
                    ram_raddr = idx_reg + addr_t'(1);
                end
            end
            S_REM_MOVE: begin
                // entry from idx+1 lands at idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + addr_t'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, COUNT_W'(occ_reg), status_reg, res_reg};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        at_reg      <= at_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    // list storage
    bole_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
